// ----- src/mtma_pkg.sv -----
// Shared types and constants for the tile GEMM engine.
package mtma_pkg;

  localparam int TILE_SIZE = 64;
  localparam int IDX_W     = $clog2(TILE_SIZE);
  localparam int ADDR_W    = 2 * IDX_W;
  localparam int DIM_W     = IDX_W + 1;
  localparam int AB_W      = 16;
  localparam int C_W       = 40;
  localparam int PROD_W    = 2 * AB_W;
  localparam int ACC_W     = PROD_W + IDX_W;
  localparam int OP_W      = 3;

  localparam logic [OP_W-1:0] OP_LOAD_A  = 3'd0;
  localparam logic [OP_W-1:0] OP_LOAD_B  = 3'd1;
  localparam logic [OP_W-1:0] OP_LOAD_C  = 3'd2;
  localparam logic [OP_W-1:0] OP_CLEAR_C = 3'd3;
  localparam logic [OP_W-1:0] OP_COMPUTE = 3'd4;
  localparam logic [OP_W-1:0] OP_READ_C  = 3'd5;

  typedef struct packed {
    logic              wr_a;
    logic              wr_b;
    logic              wr_c;
    logic              rd_c;
    logic              clr;
    logic              mac_rd;
    logic              mac_crd;
    logic              mac_cwr;
    logic [IDX_W-1:0]  i;
    logic [IDX_W-1:0]  j;
    logic [IDX_W-1:0]  k;
    logic [ADDR_W-1:0] clr_addr;
  } dp_cmd_t;

  typedef struct packed {
    logic rd_pend;
    logic out_free;
  } dp_stat_t;

endpackage

// ----- src/matrix_tile_multiply_accumulate.sv -----
// Top level of the tile GEMM engine: stream ports, APB registers, sequencer and datapath.
//
// The engine holds 64x64 tiles A, B (Q8.8) and C (Q24.16, 40 bits, saturating).
// After a load A/B/C item the next item can be taken on the following cycle; a read C
// item holds off the next item while the C memory data is registered and moved into the
// output register, through which its result leaves. While a result waits on m_tready no
// item is taken. Clear C sweeps the C memory one entry per cycle, and the next item is
// taken once all 4096 entries are cleared; the same sweep runs after reset before the
// first item is taken. Compute walks rows x cols output elements, each with one A/B
// memory read per depth step, then pipeline drain and the C read-modify-write, and the
// next item is taken once the last element is written. Dimension registers above 64 act
// as 64; a zero dimension makes compute a no-op. Register writes are honored at any time
// but must only be done while the engine is idle.
module matrix_tile_multiply_accumulate
  import mtma_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [55:0] s_tdata,   // row_index[5:0], col_index[11:6], value_in[51:12], zero pad
  input  logic [2:0]  s_tuser,   // opcode[2:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,   // value_out[39:0], row_out[45:40], col_out[51:46], zero pad
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic [1:0] REG_ROWS  = 2'd0;
  localparam logic [1:0] REG_DEPTH = 2'd1;
  localparam logic [1:0] REG_COLS  = 2'd2;

  logic [DIM_W-1:0]      tile_rows, tile_depth, tile_cols;
  logic                  cfg_wr;
  dp_cmd_t               cmd;
  dp_stat_t              stat;
  logic signed [C_W-1:0] value_out;
  logic [IDX_W-1:0]      row_out, col_out;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      tile_rows  <= DIM_W'(TILE_SIZE);
      tile_depth <= DIM_W'(TILE_SIZE);
      tile_cols  <= DIM_W'(TILE_SIZE);
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_ROWS:  tile_rows  <= pwdata[DIM_W-1:0];
        REG_DEPTH: tile_depth <= pwdata[DIM_W-1:0];
        REG_COLS:  tile_cols  <= pwdata[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_ROWS:  prdata = {(32-DIM_W)'(0), tile_rows};
      REG_DEPTH: prdata = {(32-DIM_W)'(0), tile_depth};
      REG_COLS:  prdata = {(32-DIM_W)'(0), tile_cols};
      default:   prdata = '0;
    endcase
  end

  mtma_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .opcode     (s_tuser),
    .tile_rows  (tile_rows),
    .tile_depth (tile_depth),
    .tile_cols  (tile_cols),
    .stat       (stat),
    .in_ready   (s_tready),
    .cmd        (cmd)
  );

  mtma_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .row_index (s_tdata[5:0]),
    .col_index (s_tdata[11:6]),
    .value_in  (s_tdata[51:12]),
    .out_ready (m_tready),
    .stat      (stat),
    .out_valid (m_tvalid),
    .value_out (value_out),
    .row_out   (row_out),
    .col_out   (col_out)
  );

  assign m_tdata = {4'b0, col_out, row_out, value_out};

endmodule

// ----- src/mtma_ctrl.sv -----
// Sequencer: host opcode decode, C clearing sweep and the compute triple loop.
module mtma_ctrl
  import mtma_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic [OP_W-1:0]  opcode,
  input  logic [DIM_W-1:0] tile_rows,
  input  logic [DIM_W-1:0] tile_depth,
  input  logic [DIM_W-1:0] tile_cols,
  input  dp_stat_t         stat,
  output logic             in_ready,
  output dp_cmd_t          cmd
);

  localparam logic [2:0] ST_CLR  = 3'd0;
  localparam logic [2:0] ST_IDLE = 3'd1;
  localparam logic [2:0] ST_MAC  = 3'd2;
  localparam logic [2:0] ST_DR1  = 3'd3;
  localparam logic [2:0] ST_DR2  = 3'd4;
  localparam logic [2:0] ST_CWR  = 3'd5;

  localparam logic [DIM_W-1:0] DIM_MAX = DIM_W'(TILE_SIZE);

  logic [2:0]        state, state_next;
  logic [IDX_W-1:0]  i, i_next, j, j_next, k, k_next;
  logic [ADDR_W-1:0] clr_addr, clr_addr_next;
  logic [DIM_W-1:0]  nr, nk, nc;
  logic              acc;

  assign nr = (tile_rows  > DIM_MAX) ? DIM_MAX : tile_rows;
  assign nk = (tile_depth > DIM_MAX) ? DIM_MAX : tile_depth;
  assign nc = (tile_cols  > DIM_MAX) ? DIM_MAX : tile_cols;

  assign in_ready = (state == ST_IDLE) && !stat.rd_pend && stat.out_free;
  assign acc      = in_valid && in_ready;

  always_comb begin
    state_next    = state;
    i_next        = i;
    j_next        = j;
    k_next        = k;
    clr_addr_next = clr_addr;
    cmd           = '0;
    cmd.i         = i;
    cmd.j         = j;
    cmd.k         = k;
    cmd.clr_addr  = clr_addr;
    unique case (state)
      ST_CLR: begin
        cmd.clr       = 1'b1;
        clr_addr_next = clr_addr + 1'b1;
        if (&clr_addr) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (acc) begin
          cmd.wr_a = (opcode == OP_LOAD_A);
          cmd.wr_b = (opcode == OP_LOAD_B);
          cmd.wr_c = (opcode == OP_LOAD_C);
          cmd.rd_c = (opcode == OP_READ_C);
          if (opcode == OP_CLEAR_C) begin
            clr_addr_next = '0;
            state_next    = ST_CLR;
          end else if (opcode == OP_COMPUTE && nr != '0 && nk != '0 && nc != '0) begin
            i_next     = '0;
            j_next     = '0;
            k_next     = '0;
            state_next = ST_MAC;
          end
        end
      end
      ST_MAC: begin
        cmd.mac_rd = 1'b1;
        if ({1'b0, k} == nk - 1'b1) begin
          k_next     = '0;
          state_next = ST_DR1;
        end else begin
          k_next = k + 1'b1;
        end
      end
      ST_DR1: begin
        cmd.mac_crd = 1'b1;
        state_next  = ST_DR2;
      end
      ST_DR2: begin
        state_next = ST_CWR;
      end
      ST_CWR: begin
        cmd.mac_cwr = 1'b1;
        state_next  = ST_MAC;
        if ({1'b0, j} == nc - 1'b1) begin
          j_next = '0;
          if ({1'b0, i} == nr - 1'b1) begin
            state_next = ST_IDLE;
          end else begin
            i_next = i + 1'b1;
          end
        end else begin
          j_next = j + 1'b1;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLR;
      clr_addr <= '0;
      i        <= '0;
      j        <= '0;
      k        <= '0;
    end else begin
      state    <= state_next;
      clr_addr <= clr_addr_next;
      i        <= i_next;
      j        <= j_next;
      k        <= k_next;
    end
  end

endmodule

// ----- src/mtma_dp.sv -----
// Datapath: A, B and C tile memories, multiply-accumulate pipeline, result register.
module mtma_dp
  import mtma_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  dp_cmd_t                 cmd,
  input  logic [IDX_W-1:0]        row_index,
  input  logic [IDX_W-1:0]        col_index,
  input  logic signed [C_W-1:0]   value_in,
  input  logic                    out_ready,
  output dp_stat_t                stat,
  output logic                    out_valid,
  output logic signed [C_W-1:0]   value_out,
  output logic [IDX_W-1:0]        row_out,
  output logic [IDX_W-1:0]        col_out
);

  localparam logic signed [C_W-1:0] SAT16_MAX = C_W'(32767);
  localparam logic signed [C_W-1:0] SAT16_MIN = -C_W'(32768);

  logic [AB_W-1:0] a_mem [0:TILE_SIZE*TILE_SIZE-1];
  logic [AB_W-1:0] b_mem [0:TILE_SIZE*TILE_SIZE-1];
  logic [C_W-1:0]  c_mem [0:TILE_SIZE*TILE_SIZE-1];

  logic signed [AB_W-1:0]   a_q, b_q, ab_val;
  logic [C_W-1:0]           c_q;
  logic                     rd_v1, prod_v;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc;
  logic signed [C_W:0]      c_sum;
  logic signed [C_W-1:0]    c_sat;
  logic [ADDR_W-1:0]        host_addr, cij_addr, a_addr, b_addr, c_waddr, c_raddr;
  logic [C_W-1:0]           c_wdata;
  logic                     c_we, c_re;
  logic                     rd_pend;
  logic [IDX_W-1:0]         pend_row, pend_col;

  // A and B hold Q8.8; wider inputs clamp to the 16-bit range
  always_comb begin
    if (value_in > SAT16_MAX) begin
      ab_val = AB_W'(SAT16_MAX);
    end else if (value_in < SAT16_MIN) begin
      ab_val = AB_W'(SAT16_MIN);
    end else begin
      ab_val = value_in[AB_W-1:0];
    end
  end

  assign host_addr = {row_index, col_index};
  assign cij_addr  = {cmd.i, cmd.j};
  assign a_addr    = {cmd.i, cmd.k};
  assign b_addr    = {cmd.k, cmd.j};

  assign c_sum = {c_q[C_W-1], c_q} + (C_W+1)'(acc);
  assign c_sat = (c_sum[C_W] != c_sum[C_W-1])
               ? {c_sum[C_W], {(C_W-1){~c_sum[C_W]}}}
               : c_sum[C_W-1:0];

  always_comb begin
    c_we    = cmd.wr_c || cmd.clr || cmd.mac_cwr;
    c_re    = cmd.rd_c || cmd.mac_crd;
    c_waddr = host_addr;
    c_wdata = value_in;
    if (cmd.clr) begin
      c_waddr = cmd.clr_addr;
      c_wdata = '0;
    end else if (cmd.mac_cwr) begin
      c_waddr = cij_addr;
      c_wdata = c_sat;
    end
    c_raddr = cmd.mac_crd ? cij_addr : host_addr;
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_a) begin
      a_mem[host_addr] <= ab_val;
    end
    if (cmd.wr_b) begin
      b_mem[host_addr] <= ab_val;
    end
    if (cmd.mac_rd) begin
      a_q <= a_mem[a_addr];
      b_q <= b_mem[b_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (c_we) begin
      c_mem[c_waddr] <= c_wdata;
    end
    if (c_re) begin
      c_q <= c_mem[c_raddr];
    end
  end

  always_ff @(posedge clk) begin
    prod <= a_q * b_q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_v1  <= 1'b0;
      prod_v <= 1'b0;
      acc    <= '0;
    end else begin
      rd_v1  <= cmd.mac_rd;
      prod_v <= rd_v1;
      if (cmd.mac_cwr) begin
        acc <= '0;
      end else if (prod_v) begin
        acc <= acc + ACC_W'(prod);
      end
    end
  end

  // host read: memory data lands in the cycle after the request
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pend   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      rd_pend <= cmd.rd_c;
      if (rd_pend) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_c) begin
      pend_row <= row_index;
      pend_col <= col_index;
    end
    if (rd_pend) begin
      value_out <= c_q;
      row_out   <= pend_row;
      col_out   <= pend_col;
    end
  end

  assign stat.rd_pend  = rd_pend;
  assign stat.out_free = !out_valid || out_ready;

endmodule

// ----- bench/matrix_tile_multiply_accumulate_tb.sv -----
// Testbench for the tile GEMM engine: directed table, random tile shapes, scoreboard on C reads.
module matrix_tile_multiply_accumulate_tb;
  import mtma_pkg::*;

  localparam int          TILE_CELLS  = TILE_SIZE * TILE_SIZE;
  localparam int          ITEMS_TOTAL = 1300;
  localparam int          CALM_TAIL   = 200;
  localparam int          STALL_LIMIT = 100000;
  localparam int          REG_TILE_ROWS  = 0;
  localparam int          REG_TILE_DEPTH = 1;
  localparam int          REG_TILE_COLS  = 2;
  localparam logic [2:0]  OP_UNUSED_6 = 3'd6;
  localparam logic [2:0]  OP_UNUSED_7 = 3'd7;
  localparam logic [39:0] C_MAX = 40'h7F_FFFF_FFFF;
  localparam logic [39:0] C_MIN = 40'h80_0000_0000;
  localparam longint      C_TOP = 64'sd549755813887;
  localparam longint      C_BOT = -64'sd549755813888;

  typedef struct packed {
    logic [39:0] value;
    logic [5:0]  row;
    logic [5:0]  col;
  } c_read_t;

  typedef struct packed {
    logic [2:0]  op;
    logic [5:0]  row;
    logic [5:0]  col;
    logic [39:0] val;
    bit          fixed_exp;
    logic [39:0] want;
  } dir_step_t;

  logic        clk;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [55:0] s_tdata  = '0;  // row_index[5:0], col_index[11:6], value_in[51:12], zero pad
  logic [2:0]  s_tuser  = '0;  // opcode[2:0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [55:0] m_tdata;        // value_out[39:0], row_out[45:40], col_out[51:46], zero pad
  logic        psel     = 1'b0;
  logic        penable  = 1'b0;
  logic        pwrite   = 1'b0;
  logic [3:0]  paddr    = '0;
  logic [31:0] pwdata   = '0;
  logic [31:0] prdata;
  logic        pready;

  matrix_tile_multiply_accumulate u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Tile model
  logic signed [15:0] a_mem [TILE_CELLS];
  logic signed [15:0] b_mem [TILE_CELLS];
  logic signed [39:0] c_mem [TILE_CELLS];
  bit                 a_set [TILE_CELLS];
  bit                 b_set [TILE_CELLS];
  logic [6:0]         dim_r, dim_k, dim_c;
  c_read_t            pending_reads [$];

  bit sender_gaps = 1'b1;
  bit sink_stalls = 1'b1;
  int mismatches  = 0;
  int n_items = 0, n_computes = 0, n_clears = 0, n_reads = 0, n_phases = 0;
  int idle_cycles = 0;

  dir_step_t directed_steps [24] = '{
    '{OP_READ_C,   6'd0,  6'd0,  40'd0,           1'b1, 40'd0},
    '{OP_READ_C,   6'd63, 6'd63, C_MIN,           1'b1, 40'd0},
    '{OP_LOAD_C,   6'd63, 6'd63, C_MAX,           1'b0, 40'd0},
    '{OP_READ_C,   6'd63, 6'd63, 40'd0,           1'b1, C_MAX},
    '{OP_LOAD_C,   6'd0,  6'd63, C_MIN,           1'b0, 40'd0},
    '{OP_READ_C,   6'd0,  6'd63, 40'd0,           1'b1, C_MIN},
    '{OP_LOAD_A,   6'd0,  6'd0,  C_MAX,           1'b0, 40'd0},
    '{OP_LOAD_B,   6'd0,  6'd0,  C_MIN,           1'b0, 40'd0},
    '{OP_COMPUTE,  6'd0,  6'd0,  40'd0,           1'b0, 40'd0},
    '{OP_READ_C,   6'd0,  6'd0,  40'd0,           1'b0, 40'd0},
    '{OP_LOAD_C,   6'd0,  6'd0,  C_MIN,           1'b0, 40'd0},
    '{OP_COMPUTE,  6'd0,  6'd0,  40'd0,           1'b0, 40'd0},
    '{OP_READ_C,   6'd0,  6'd0,  40'd0,           1'b1, C_MIN},
    '{OP_LOAD_A,   6'd0,  6'd0,  40'hFF_FFFF_8000, 1'b0, 40'd0},
    '{OP_LOAD_C,   6'd0,  6'd0,  40'h7F_FFFF_FFFA, 1'b0, 40'd0},
    '{OP_COMPUTE,  6'd0,  6'd0,  40'd0,           1'b0, 40'd0},
    '{OP_READ_C,   6'd0,  6'd0,  40'd0,           1'b1, C_MAX},
    '{OP_UNUSED_6, 6'd63, 6'd63, 40'hFF_FFFF_FFFF, 1'b0, 40'd0},
    '{OP_UNUSED_7, 6'd0,  6'd0,  40'd0,           1'b0, 40'd0},
    '{OP_CLEAR_C,  6'd0,  6'd0,  40'd0,           1'b0, 40'd0},
    '{OP_READ_C,   6'd63, 6'd63, 40'd0,           1'b1, 40'd0},
    '{OP_READ_C,   6'd0,  6'd0,  40'd0,           1'b1, 40'd0},
    '{OP_LOAD_A,   6'd63, 6'd63, 40'h00_0000_8000, 1'b0, 40'd0},
    '{OP_LOAD_B,   6'd63, 6'd63, 40'hFF_FFFF_7FFF, 1'b0, 40'd0}
  };

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic signed [15:0] clip16(input longint v);
    if (v > 32767) return 16'sh7FFF;
    if (v < -32768) return 16'sh8000;
    return 16'(v);
  endfunction

  function automatic logic [39:0] clip40(input longint v);
    if (v > C_TOP) return C_MAX;
    if (v < C_BOT) return C_MIN;
    return 40'(v);
  endfunction

  function automatic int eff_dim(input logic [6:0] d);
    return (d > 7'd64) ? 64 : int'(d);
  endfunction

  function automatic void mac_tile();
    int     er, ek, ec;
    longint acc;
    er = eff_dim(dim_r);
    ek = eff_dim(dim_k);
    ec = eff_dim(dim_c);
    for (int i = 0; i < er; i++) begin
      for (int j = 0; j < ec; j++) begin
        acc = 0;
        for (int k = 0; k < ek; k++)
          acc += longint'(a_mem[i*TILE_SIZE+k]) * longint'(b_mem[k*TILE_SIZE+j]);
        c_mem[i*TILE_SIZE+j] = clip40(longint'(c_mem[i*TILE_SIZE+j]) + acc);
      end
    end
  endfunction

  // Returns 1 when the item produces a C read result.
  function automatic bit apply_item(input logic [2:0] op, input logic [5:0] row, col,
                                    input logic [39:0] val, output c_read_t r);
    int unsigned at;
    longint      sv;
    at = 32'({row, col});
    sv = longint'($signed(val));
    r  = '0;
    case (op)
      OP_LOAD_A: begin
        a_mem[at] = clip16(sv);
        a_set[at] = 1'b1;
      end
      OP_LOAD_B: begin
        b_mem[at] = clip16(sv);
        b_set[at] = 1'b1;
      end
      OP_LOAD_C:  c_mem[at] = val;
      OP_CLEAR_C: for (int n = 0; n < TILE_CELLS; n++) c_mem[n] = '0;
      OP_COMPUTE: mac_tile();
      OP_READ_C: begin
        r.value = c_mem[at];
        r.row   = row;
        r.col   = col;
        return 1'b1;
      end
      default: ;
    endcase
    return 1'b0;
  endfunction

  function automatic logic [39:0] rand40();
    return {8'($urandom()), $urandom()};
  endfunction

  function automatic logic [39:0] ab_value();
    logic [15:0] x;
    int          pick;
    x    = 16'($urandom());
    pick = $urandom_range(0, 9);
    if (pick < 7) return {{24{x[15]}}, x};
    if (pick == 7) return rand40();
    if (pick == 8) return x[0] ? C_MAX : C_MIN;
    // just around the Q8.8 limits
    return x[0] ? 40'(longint'(32766) + $urandom_range(0, 3))
                : 40'(longint'(-32769) + $urandom_range(0, 3));
  endfunction

  function automatic logic [39:0] c_value();
    logic [23:0] x;
    int          pick;
    longint      off;
    x    = 24'($urandom());
    pick = $urandom_range(0, 9);
    off  = longint'($urandom()) << $urandom_range(0, 4);
    if (pick < 6) return {{16{x[23]}}, x};
    if (pick < 8) return rand40();
    // close enough to the rails for an accumulate to saturate
    if (pick == 8) return 40'(C_TOP - off);
    return 40'(C_BOT + off);
  endfunction

  function automatic logic [5:0] pick_idx(input int lim);
    if (lim > 0 && $urandom_range(0, 9) < 7) return 6'($urandom_range(0, lim - 1));
    return 6'($urandom_range(0, 63));
  endfunction

  task automatic send_item(input logic [2:0] op, input logic [5:0] row, col,
                           input logic [39:0] val, input bit fixed_exp,
                           input logic [39:0] want);
    c_read_t r;
    if (sender_gaps && $urandom_range(0, 99) < 12) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {4'b0, val, col, row};
    do @(posedge clk); while (!s_tready);
    if (apply_item(op, row, col, val, r)) begin
      if (fixed_exp) r.value = want;
      pending_reads.push_back(r);
    end
    case (op)
      OP_COMPUTE: n_computes++;
      OP_CLEAR_C: n_clears++;
      OP_READ_C:  n_reads++;
      default: ;
    endcase
    if (op <= OP_READ_C) n_items++;
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending_reads.size() != 0);
  endtask

  task automatic apb_write(input int idx, input logic [6:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 4'(idx * 4);
    pwdata  <= 32'(v);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apb_check(input int idx, input logic [31:0] want);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= 4'(idx * 4);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== want) begin
      $error("register %0d: expected %0d, got %0d", idx, want, prdata);
      mismatches++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_shape(input logic [6:0] r, k, c);
    apb_write(REG_TILE_ROWS, r);
    apb_write(REG_TILE_DEPTH, k);
    apb_write(REG_TILE_COLS, c);
    dim_r = r;
    dim_k = k;
    dim_c = c;
    apb_check(REG_TILE_ROWS, 32'(r));
    apb_check(REG_TILE_DEPTH, 32'(k));
    apb_check(REG_TILE_COLS, 32'(c));
  endtask

  // A and B entries read by the next compute must have been written first
  task automatic fill_operands(input int er, ek, ec);
    for (int i = 0; i < er; i++)
      for (int k = 0; k < ek; k++)
        if (!a_set[i*TILE_SIZE+k])
          send_item(OP_LOAD_A, 6'(i), 6'(k), ab_value(), 1'b0, '0);
    for (int k = 0; k < ek; k++)
      for (int j = 0; j < ec; j++)
        if (!b_set[k*TILE_SIZE+j])
          send_item(OP_LOAD_B, 6'(k), 6'(j), ab_value(), 1'b0, '0);
  endtask

  task automatic run_phase(input int count);
    int er, ek, ec, pick;
    er = eff_dim(dim_r);
    ek = eff_dim(dim_k);
    ec = eff_dim(dim_c);
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 99) < 4) wait_drained();
      pick = $urandom_range(0, 99);
      if (pick < 20)
        send_item(OP_LOAD_A, pick_idx(er), pick_idx(ek), ab_value(), 1'b0, '0);
      else if (pick < 40)
        send_item(OP_LOAD_B, pick_idx(ek), pick_idx(ec), ab_value(), 1'b0, '0);
      else if (pick < 52)
        send_item(OP_LOAD_C, pick_idx(er), pick_idx(ec), c_value(), 1'b0, '0);
      else if (pick < 78)
        send_item(OP_READ_C, pick_idx(er), pick_idx(ec), rand40(), 1'b0, '0);
      else if (pick < 93) begin
        fill_operands(er, ek, ec);
        send_item(OP_COMPUTE, pick_idx(0), pick_idx(0), rand40(), 1'b0, '0);
      end else if (pick < 96)
        send_item(OP_CLEAR_C, pick_idx(0), pick_idx(0), rand40(), 1'b0, '0);
      else
        send_item(3'($urandom_range(6, 7)), pick_idx(0), pick_idx(0), rand40(), 1'b0, '0);
    end
    // a closing read cannot be taken before a compute or clear has finished
    send_item(OP_READ_C, pick_idx(er), pick_idx(ec), rand40(), 1'b0, '0);
    wait_drained();
    repeat (8) @(posedge clk);
  endtask

  function automatic logic [6:0] rand_dim(input bool_big, input int small_max);
    if (bool_big) return ($urandom_range(0, 3) == 0) ? 7'd64 : 7'($urandom_range(64, 127));
    if ($urandom_range(0, 9) == 0) return 7'd0;
    return 7'($urandom_range(1, small_max));
  endfunction

  initial begin : sink_ctl
    int n;
    forever begin
      @(posedge clk);
      if (sink_stalls && $urandom_range(0, 99) < 25) begin
        m_tready <= 1'b0;
        n = $urandom_range(1, 19);
        repeat (n) @(posedge clk);
        m_tready <= 1'b1;
      end else begin
        m_tready <= 1'b1;
        repeat ($urandom_range(0, 15)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin : result_check
    c_read_t     w;
    logic [39:0] got_v;
    logic [5:0]  got_r, got_c;
    if (!rst && m_tvalid && m_tready) begin
      got_v = m_tdata[39:0];
      got_r = m_tdata[45:40];
      got_c = m_tdata[51:46];
      if (pending_reads.size() == 0) begin
        $error("unexpected result transaction: value_out %0d row_out %0d col_out %0d",
               $signed(got_v), got_r, got_c);
        mismatches++;
      end else begin
        w = pending_reads.pop_front();
        if (got_v !== w.value) begin
          $error("value_out: expected %0d, got %0d", $signed(w.value), $signed(got_v));
          mismatches++;
        end
        if (got_r !== w.row) begin
          $error("row_out: expected %0d, got %0d", w.row, got_r);
          mismatches++;
        end
        if (got_c !== w.col) begin
          $error("col_out: expected %0d, got %0d", w.col, got_c);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
      idle_cycles <= 0;
    else if (idle_cycles >= STALL_LIMIT) begin
      $display("matrix_tile_multiply_accumulate_tb: done, errors");
      $finish;
    end else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin : stimulus
    bit big_pick;
    int big;
    for (int n = 0; n < TILE_CELLS; n++) begin
      a_mem[n] = '0;
      b_mem[n] = '0;
      c_mem[n] = '0;
      a_set[n] = 1'b0;
      b_set[n] = 1'b0;
    end
    dim_r = 7'd64;
    dim_k = 7'd64;
    dim_c = 7'd64;

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    apb_check(REG_TILE_ROWS, 32'd64);
    apb_check(REG_TILE_DEPTH, 32'd64);
    apb_check(REG_TILE_COLS, 32'd64);
    set_shape(7'd1, 7'd1, 7'd1);

    foreach (directed_steps[n])
      send_item(directed_steps[n].op, directed_steps[n].row, directed_steps[n].col,
                directed_steps[n].val, directed_steps[n].fixed_exp, directed_steps[n].want);
    wait_drained();
    repeat (8) @(posedge clk);

    while (n_items < ITEMS_TOTAL) begin
      sender_gaps = (n_items < ITEMS_TOTAL - CALM_TAIL) && ($urandom_range(0, 3) != 0);
      sink_stalls = (n_items < ITEMS_TOTAL - CALM_TAIL) && ($urandom_range(0, 3) != 0);
      // zero, over-range and full-width dimensions first, then random shapes
      case (n_phases)
        0: set_shape(7'd0, 7'd3, 7'd3);
        1: set_shape(7'd3, 7'd0, 7'd3);
        2: set_shape(7'd3, 7'd3, 7'd0);
        3: set_shape(7'd127, 7'd1, 7'd2);
        4: set_shape(7'd2, 7'd127, 7'd1);
        5: set_shape(7'd1, 7'd2, 7'd127);
        6: set_shape(7'd64, 7'd1, 7'd64);
        7: set_shape(7'd1, 7'd64, 7'd1);
        default: begin
          // at most one wide dimension, so computes and operand fills stay short
          big = $urandom_range(0, 3);
          big_pick = (big != 3);
          set_shape(rand_dim(big == 0, big_pick ? 2 : 6),
                    rand_dim(big == 1, big_pick ? 2 : 6),
                    rand_dim(big == 2, big_pick ? 2 : 6));
        end
      endcase
      n_phases++;
      run_phase($urandom_range(20, 60));
    end

    wait_drained();
    repeat (16) @(posedge clk);

    $display("matrix_tile_multiply_accumulate_tb: %0d items: %0d computes, %0d clears, %0d C reads",
             n_items, n_computes, n_clears, n_reads);
    $display("matrix_tile_multiply_accumulate_tb: %0d tile shapes incl. zero, over-range, 64-wide",
             n_phases + 1);
    if (mismatches == 0)
      $display("matrix_tile_multiply_accumulate_tb: done, clean");
    else
      $display("matrix_tile_multiply_accumulate_tb: done, errors");
    $finish;
  end

endmodule

// ----- matrix_tile_multiply_accumulate.f -----
src/mtma_pkg.sv
src/mtma_ctrl.sv
src/mtma_dp.sv
src/matrix_tile_multiply_accumulate.sv
bench/matrix_tile_multiply_accumulate_tb.sv
